// File: hdl/pbis_pkg.sv
// Shared types and constants for the packet buffer id store.
package pbis_pkg;

    // Field widths fixed by the transaction format.
    localparam int KIND_W   = 2;
    localparam int HANDLE_W = 32;
    localparam int ID_W     = 31;
    localparam int TIME_W   = 32;
    localparam int OCC_W    = 7;
    localparam int LIMIT_W  = 7;
    localparam int EXPIRY_W = 16;
    localparam int CFG_W    = 16;
    localparam int IDCNT_W  = 32;

    // Operation codes carried in the kind field.
    localparam logic [KIND_W-1:0] KIND_STORE    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RETRIEVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EXPIRY   = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_CAPACITY_LIMIT = 1'b0;
    localparam logic CFG_EXPIRY_SECONDS = 1'b1;

    // Configuration reset values.
    localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 7'd64;
    localparam logic [EXPIRY_W-1:0] EXPIRY_RESET = 16'd60;
    localparam logic [IDCNT_W-1:0]  IDCNT_RESET  = 32'd1;

    // Command transaction.
    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [HANDLE_W-1:0] packet_handle;
        logic [ID_W-1:0]     lookup_id;
        logic [TIME_W-1:0]   now_seconds;
    } pbis_cmd_t;

    // Result transaction.
    typedef struct packed {
        logic                ok;
        logic [ID_W-1:0]     result_id;
        logic [HANDLE_W-1:0] result_handle;
        logic [OCC_W-1:0]    occupancy;
    } pbis_rsp_t;

    // One stored table entry.
    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [ID_W-1:0]     id;
        logic [TIME_W-1:0]   stamp;
    } pbis_entry_t;

    localparam int ENTRY_W = $bits(pbis_entry_t);

endpackage

// File: hdl/pbis_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module pbis_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hdl/packet_buffer_id_store_top.sv
// Top level of the packet buffer id store: sequencer around one entry RAM.
// Store finishes in the execute state; expiry check reads entry 0 there
// and decides in the expiry state. Retrieve: search and compaction walk
// the RAM one entry per cycle, so a retrieve takes longer as occupancy grows.
// One command is in flight at a time; busy is high until its result shows.
// Asynchronous active-low reset empties the table, sets the id counter to
// one and loads the register defaults; RAM contents are not cleared.
module packet_buffer_id_store_top #(
    parameter int CAPACITY = 64
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  pbis_pkg::pbis_cmd_t                  cmd,
    output logic                                 done,
    output pbis_pkg::pbis_rsp_t                  result,
    input  logic                                 cfg_we,
    input  logic                                 cfg_index,
    input  logic [pbis_pkg::CFG_W-1:0]           cfg_data
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = CAPACITY > 1 ? $clog2(CAPACITY) : 1;
    localparam int LW = CW > pbis_pkg::LIMIT_W ? CW : pbis_pkg::LIMIT_W;
    localparam int OW = pbis_pkg::OCC_W;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EXEC   = 3'd1;
    localparam logic [2:0] ST_EXP    = 3'd2;
    localparam logic [2:0] ST_SEARCH = 3'd3;
    localparam logic [2:0] ST_SHIFT  = 3'd4;

    logic [2:0]                          state_reg, state_next;
    logic [CW-1:0]                       count_reg, count_next;
    logic [CW-1:0]                       rd_idx_reg, rd_idx_next;
    logic [pbis_pkg::IDCNT_W-1:0]        idc_reg, idc_next;
    logic [pbis_pkg::LIMIT_W-1:0]        limit_reg;
    logic [pbis_pkg::EXPIRY_W-1:0]       expiry_reg;
    pbis_pkg::pbis_cmd_t                 cmd_reg, cmd_next;
    pbis_pkg::pbis_rsp_t                 rsp_reg, rsp_next;
    logic                                done_reg, done_next;

    logic                                ram_we;
    logic [AW-1:0]                       ram_waddr;
    pbis_pkg::pbis_entry_t               ram_wdata;
    logic [AW-1:0]                       ram_raddr;
    pbis_pkg::pbis_entry_t               ram_rdata;

    logic                                room;
    logic [CW-1:0]                       count_plus;
    logic [CW-1:0]                       count_minus;
    logic [CW-1:0]                       rd_idx_plus;
    logic [CW-1:0]                       shift_waddr;
    logic [pbis_pkg::IDCNT_W-1:0]        idc_plus;
    logic [pbis_pkg::TIME_W-1:0]         age;

    logic                                fin;
    logic                                fin_ok;
    logic [pbis_pkg::ID_W-1:0]           fin_id;
    logic [pbis_pkg::HANDLE_W-1:0]       fin_handle;
    logic [CW-1:0]                       fin_count;

    // Entry memory: handle, id and time stamp side by side.
    pbis_ram #(
        .WIDTH (pbis_pkg::ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Arithmetic shared by the sequencer.
    assign count_plus  = count_reg + CW'(1);
    assign count_minus = count_reg - CW'(1);
    assign rd_idx_plus = rd_idx_reg + CW'(1);
    assign shift_waddr = rd_idx_reg - CW'(2);
    assign idc_plus    = idc_reg + pbis_pkg::IDCNT_W'(1);
    assign age         = cmd_reg.now_seconds - ram_rdata.stamp;
    assign room        = (LW'(count_reg) < LW'(limit_reg)) && (count_reg < CW'(CAPACITY));

    // Sequencer: dispatch, search, compaction and result assembly.
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        rd_idx_next = rd_idx_reg;
        idc_next    = idc_reg;
        cmd_next    = cmd_reg;
        rsp_next    = rsp_reg;
        done_next   = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = count_reg[AW-1:0];
        ram_wdata   = ram_rdata;
        ram_raddr   = rd_idx_reg[AW-1:0];
        fin         = 1'b0;
        fin_ok      = 1'b0;
        fin_id      = '0;
        fin_handle  = '0;
        fin_count   = count_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd_next   = cmd;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // Entry 0 is read here for both the search and the expiry check.
                ram_raddr = '0;
                unique case (cmd_reg.kind)
                    pbis_pkg::KIND_STORE:
                    begin
                        fin = 1'b1;
                        if (room)
                        begin
                            ram_we     = 1'b1;
                            ram_waddr  = count_reg[AW-1:0];
                            ram_wdata  = '{handle: cmd_reg.packet_handle,
                                           id:     idc_plus[pbis_pkg::ID_W-1:0],
                                           stamp:  cmd_reg.now_seconds};
                            idc_next   = idc_plus;
                            count_next = count_plus;
                            fin_ok     = 1'b1;
                            fin_id     = idc_plus[pbis_pkg::ID_W-1:0];
                            fin_count  = count_plus;
                        end
                    end
                    pbis_pkg::KIND_RETRIEVE:
                    begin
                        if (count_reg == '0)
                        begin
                            fin = 1'b1;
                        end
                        else
                        begin
                            rd_idx_next = CW'(1);
                            state_next  = ST_SEARCH;
                        end
                    end
                    pbis_pkg::KIND_EXPIRY:
                    begin
                        state_next = ST_EXP;
                    end
                    default:
                    begin
                        fin = 1'b1;
                    end
                endcase
            end
            ST_EXP:
            begin
                fin = 1'b1;
                if ((count_reg != '0) && (age > pbis_pkg::TIME_W'(expiry_reg)))
                begin
                    fin_ok = 1'b1;
                    fin_id = ram_rdata.id;
                end
            end
            ST_SEARCH:
            begin
                // Read data belongs to entry rd_idx - 1; the next read is issued ahead.
                if (ram_rdata.id == cmd_reg.lookup_id)
                begin
                    rsp_next.result_handle = ram_rdata.handle;
                    if (rd_idx_reg == count_reg)
                    begin
                        fin        = 1'b1;
                        fin_ok     = 1'b1;
                        fin_handle = ram_rdata.handle;
                        fin_count  = count_minus;
                        count_next = count_minus;
                    end
                    else
                    begin
                        rd_idx_next = rd_idx_plus;
                        state_next  = ST_SHIFT;
                    end
                end
                else if (rd_idx_reg == count_reg)
                begin
                    fin = 1'b1;
                end
                else
                begin
                    rd_idx_next = rd_idx_plus;
                end
            end
            ST_SHIFT:
            begin
                // Move entry rd_idx - 1 down by one place to close the gap.
                ram_we    = 1'b1;
                ram_waddr = shift_waddr[AW-1:0];
                ram_wdata = ram_rdata;
                if (rd_idx_reg == count_reg)
                begin
                    fin        = 1'b1;
                    fin_ok     = 1'b1;
                    fin_handle = rsp_reg.result_handle;
                    fin_count  = count_minus;
                    count_next = count_minus;
                end
                else
                begin
                    rd_idx_next = rd_idx_plus;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Completion: load the result transaction and return to idle.
        if (fin)
        begin
            done_next  = 1'b1;
            state_next = ST_IDLE;
            rsp_next   = '{ok:            fin_ok,
                           result_id:     fin_id,
                           result_handle: fin_handle,
                           occupancy:     OW'(fin_count)};
        end
    end

    // Control state and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            rd_idx_reg <= '0;
            idc_reg    <= pbis_pkg::IDCNT_RESET;
            done_reg   <= 1'b0;
            limit_reg  <= pbis_pkg::LIMIT_RESET;
            expiry_reg <= pbis_pkg::EXPIRY_RESET;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            rd_idx_reg <= rd_idx_next;
            idc_reg    <= idc_next;
            done_reg   <= done_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    pbis_pkg::CFG_CAPACITY_LIMIT:
                    begin
                        limit_reg <= cfg_data[pbis_pkg::LIMIT_W-1:0];
                    end
                    pbis_pkg::CFG_EXPIRY_SECONDS:
                    begin
                        expiry_reg <= cfg_data[pbis_pkg::EXPIRY_W-1:0];
                    end
                    default:
                    begin
                        limit_reg <= limit_reg;
                    end
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        rsp_reg <= rsp_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = rsp_reg;

endmodule

// File: hdl/pbis_chk.sv
// Port-level checker for the packet buffer id store, bound to the top level.
module pbis_chk (
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic                done,
    input pbis_pkg::pbis_rsp_t result
);

    // An accepted transaction makes the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("block not busy after an accepted transaction");

    // A result only follows a cycle of work.
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without work in progress");

    // Results of two transactions never show in adjacent cycles.
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held longer than one cycle");

    // An idle block with no request produces no result.
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !busy && !start |=> !done)
        else $error("result strobe without an accepted transaction");

    // A failed transaction never returns a handle.
    a_miss_handle: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.ok |-> result.result_handle == '0)
        else $error("handle returned on a failed transaction");

endmodule

bind packet_buffer_id_store_top pbis_chk u_pbis_chk (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

// File: tb/packet_buffer_id_store_top_tb.sv
// Self-checking testbench for the packet buffer id store top level.
module packet_buffer_id_store_top_tb;

    localparam int TABLE_DEPTH = 64;
    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 100;
    localparam int PHASE_ITEMS = 170;
    localparam int PHASE_COUNT = 8;
    localparam logic [pbis_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

    // A queued command, with hints that are resolved against the live table when it is driven.
    typedef struct {
        pbis_pkg::pbis_cmd_t         cmd;
        bit                          pick_live_id;
        bit                          aim_expiry;
        logic [pbis_pkg::TIME_W-1:0] aim_offset;
    } pending_cmd_t;

    logic                          clk;
    logic                          rst_n = 1'b0;
    logic                          start = 1'b0;
    logic                          busy;
    pbis_pkg::pbis_cmd_t           cmd = '0;
    logic                          done;
    pbis_pkg::pbis_rsp_t           result;
    logic                          cfg_we = 1'b0;
    logic                          cfg_index = pbis_pkg::CFG_CAPACITY_LIMIT;
    logic [pbis_pkg::CFG_W-1:0]    cfg_data = '0;

    pending_cmd_t                  cmd_backlog[$];
    pbis_pkg::pbis_rsp_t           expected_answers[$];
    int unsigned                   fail_count = 0;
    int unsigned                   idle_left = 0;
    int unsigned                   quiet_cycles = 0;
    bit                            steady_mode = 1'b0;

    // Shadow copy of the table, the id counter and the registers.
    logic [pbis_pkg::HANDLE_W-1:0] tbl_handle [TABLE_DEPTH];
    logic [pbis_pkg::ID_W-1:0]     tbl_id     [TABLE_DEPTH];
    logic [pbis_pkg::TIME_W-1:0]   tbl_stamp  [TABLE_DEPTH];
    int unsigned                   tbl_count = 0;
    logic [pbis_pkg::IDCNT_W-1:0]  id_seq = pbis_pkg::IDCNT_RESET;
    logic [pbis_pkg::LIMIT_W-1:0]  limit_reg = pbis_pkg::LIMIT_RESET;
    logic [pbis_pkg::EXPIRY_W-1:0] expiry_reg = pbis_pkg::EXPIRY_RESET;

    packet_buffer_id_store_top #(.CAPACITY(TABLE_DEPTH)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Apply one accepted command to the shadow table and return the answer it must produce.
    function automatic pbis_pkg::pbis_rsp_t apply_to_table(input pbis_pkg::pbis_cmd_t c);
        pbis_pkg::pbis_rsp_t         r;
        int unsigned                 lim;
        int                          hit;
        logic [pbis_pkg::TIME_W-1:0] age;
        r = '0;
        hit = -1;
        lim = (limit_reg < TABLE_DEPTH) ? limit_reg : TABLE_DEPTH;
        case (c.kind)
            pbis_pkg::KIND_STORE:
            begin
                if (tbl_count < lim)
                begin
                    id_seq = id_seq + 1;
                    tbl_handle[tbl_count] = c.packet_handle;
                    tbl_id[tbl_count] = id_seq[pbis_pkg::ID_W-1:0];
                    tbl_stamp[tbl_count] = c.now_seconds;
                    tbl_count++;
                    r.ok = 1'b1;
                    r.result_id = id_seq[pbis_pkg::ID_W-1:0];
                end
            end
            pbis_pkg::KIND_RETRIEVE:
            begin
                for (int i = 0; i < tbl_count; i++)
                begin
                    if (hit < 0 && tbl_id[i] == c.lookup_id)
                        hit = i;
                end
                if (hit >= 0)
                begin
                    r.ok = 1'b1;
                    r.result_handle = tbl_handle[hit];
                    // Later entries move down one slot so insertion order is kept.
                    for (int j = hit; j + 1 < tbl_count; j++)
                    begin
                        tbl_handle[j] = tbl_handle[j + 1];
                        tbl_id[j] = tbl_id[j + 1];
                        tbl_stamp[j] = tbl_stamp[j + 1];
                    end
                    tbl_count--;
                end
            end
            pbis_pkg::KIND_EXPIRY:
            begin
                if (tbl_count > 0)
                begin
                    age = c.now_seconds - tbl_stamp[0];
                    if (age > {16'd0, expiry_reg})
                    begin
                        r.ok = 1'b1;
                        r.result_id = tbl_id[0];
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.occupancy = tbl_count[pbis_pkg::OCC_W-1:0];
        return r;
    endfunction

    // Fill in ids and times that depend on the table contents at issue time.
    function automatic pbis_pkg::pbis_cmd_t resolve_pending(input pending_cmd_t p);
        pbis_pkg::pbis_cmd_t c;
        int unsigned         slot;
        c = p.cmd;
        if (tbl_count > 0)
        begin
            if (p.pick_live_id)
            begin
                case ($urandom_range(0, 3))
                    0: slot = 0;
                    1: slot = tbl_count - 1;
                    default: slot = $urandom_range(0, tbl_count - 1);
                endcase
                c.lookup_id = tbl_id[slot];
            end
            if (p.aim_expiry)
                c.now_seconds = tbl_stamp[0] + {16'd0, expiry_reg} + p.aim_offset;
        end
        return c;
    endfunction

    // Mostly back-to-back, sometimes short pauses, rarely long ones.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (steady_mode || r < 12)
            return 0;
        else if (r < 18)
            return $urandom_range(1, 4);
        else
            return $urandom_range(10, 40);
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%s", msg);
    endtask

    task automatic add_cmd(input logic [pbis_pkg::KIND_W-1:0]   kind,
                           input logic [pbis_pkg::HANDLE_W-1:0] handle,
                           input logic [pbis_pkg::ID_W-1:0]     lookup,
                           input logic [pbis_pkg::TIME_W-1:0]   now,
                           input bit                            live,
                           input bit                            aim,
                           input logic [pbis_pkg::TIME_W-1:0]   offset);
        pending_cmd_t p;
        p.cmd.kind = kind;
        p.cmd.packet_handle = handle;
        p.cmd.lookup_id = lookup;
        p.cmd.now_seconds = now;
        p.pick_live_id = live;
        p.aim_expiry = aim;
        p.aim_offset = offset;
        cmd_backlog.insert(cmd_backlog.size(), p);
    endtask

    // Called at a clock edge; the write lands at the next edge. The caller lowers cfg_we.
    task automatic write_register(input logic idx, input logic [pbis_pkg::CFG_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        if (idx == pbis_pkg::CFG_CAPACITY_LIMIT)
            limit_reg = value[pbis_pkg::LIMIT_W-1:0];
        else
            expiry_reg = value[pbis_pkg::EXPIRY_W-1:0];
    endtask

    task automatic set_registers(input logic [pbis_pkg::CFG_W-1:0] limit,
                                 input logic [pbis_pkg::CFG_W-1:0] expiry);
        @(posedge clk);
        write_register(pbis_pkg::CFG_CAPACITY_LIMIT, limit);
        write_register(pbis_pkg::CFG_EXPIRY_SECONDS, expiry);
        cfg_we <= 1'b0;
    endtask

    // Wait until every queued command has been issued and answered.
    task automatic wait_idle();
        while (cmd_backlog.size() != 0 || expected_answers.size() != 0 || start || busy)
            @(posedge clk);
    endtask

    // Command driver: one transaction is accepted when start is high and busy is low.
    always @(posedge clk)
    begin : drive_cmds
        bit took;
        if (rst_n)
        begin
            took = start && !busy;
            if (took)
            begin
                expected_answers.insert(expected_answers.size(), apply_to_table(cmd));
                idle_left = pick_gap();
            end
            if (start && !took)
            begin
                // Hold the command until the block takes it.
            end
            else if (idle_left > 0)
            begin
                idle_left--;
                start <= 1'b0;
            end
            else if (cmd_backlog.size() > 0)
            begin
                cmd <= resolve_pending(cmd_backlog.pop_front());
                start <= 1'b1;
            end
            else
                start <= 1'b0;
        end
    end

    // Result monitor: each strobed result is checked against the oldest expectation.
    always @(posedge clk)
    begin : check_results
        pbis_pkg::pbis_rsp_t want;
        if (rst_n && done === 1'b1)
        begin
            if (expected_answers.size() == 0)
                note_failure($sformatf("unexpected result ok=%0d id=%h handle=%h occ=%0d",
                                       result.ok, result.result_id, result.result_handle,
                                       result.occupancy));
            else
            begin
                want = expected_answers.pop_front();
                if (result.ok !== want.ok || result.result_id !== want.result_id ||
                    result.result_handle !== want.result_handle ||
                    result.occupancy !== want.occupancy)
                    note_failure({
                        $sformatf("mismatch: expected ok=%0d id=%h handle=%h occ=%0d, ",
                                  want.ok, want.result_id, want.result_handle,
                                  want.occupancy),
                        $sformatf("got ok=%0d id=%h handle=%h occ=%0d",
                                  result.ok, result.result_id, result.result_handle,
                                  result.occupancy)});
            end
        end
    end

    // Watchdog: too long without an accepted command or a result ends the run.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done === 1'b1)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("packet_buffer_id_store_top_tb failed");
                $finish;
            end
        end
    end

    // Stimulus: directed checks first, then random phases under several register settings.
    initial
    begin : stimulus
        logic [pbis_pkg::CFG_W-1:0]  phase_limit  [PHASE_COUNT];
        logic [pbis_pkg::CFG_W-1:0]  phase_expiry [PHASE_COUNT];
        logic [pbis_pkg::TIME_W-1:0] clock_now;
        logic [pbis_pkg::TIME_W-1:0] offset;
        int unsigned                 sw;
        int unsigned                 r;
        int unsigned                 rem;

        phase_limit  = '{16'd64, 16'd1, 16'd127, 16'd0, 16'd33, 16'd64, 16'd2, 16'd100};
        phase_expiry = '{16'd60, 16'd5, 16'd1000, 16'd0, 16'd0, 16'hFFFF, 16'd2, 16'd30};
        phase_expiry[4] = pbis_pkg::CFG_W'($urandom_range(0, 65535));
        clock_now = $urandom_range(0, 100000);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset defaults: empty table, time wrap, boundary ages, removal from every position.
        add_cmd(pbis_pkg::KIND_EXPIRY, 32'h0, 31'h0, 32'h0, 0, 0, 0);
        add_cmd(pbis_pkg::KIND_RETRIEVE, 32'h0, 31'h7FFF_FFFF, 32'h0, 0, 0, 0);
        add_cmd(KIND_UNUSED, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0);
        add_cmd(pbis_pkg::KIND_STORE, 32'hFFFF_FFFF, 31'h0, 32'hFFFF_FFF0, 0, 0, 0);
        add_cmd(pbis_pkg::KIND_STORE, 32'h0, 31'h7FFF_FFFF, 32'h10, 0, 0, 0);
        add_cmd(pbis_pkg::KIND_STORE, 32'hA5A5_A5A5, 31'h0, 32'h14, 0, 0, 0);
        add_cmd(pbis_pkg::KIND_EXPIRY, 32'h0, 31'h0, 32'h2C, 0, 0, 0);
        add_cmd(pbis_pkg::KIND_EXPIRY, 32'h0, 31'h0, 32'h2D, 0, 0, 0);
        add_cmd(pbis_pkg::KIND_EXPIRY, 32'h0, 31'h0, 32'hFFFF_FFEF, 0, 0, 0);
        add_cmd(pbis_pkg::KIND_RETRIEVE, 32'hFFFF_FFFF, 31'd3, 32'h0, 0, 0, 0);
        add_cmd(pbis_pkg::KIND_RETRIEVE, 32'h0, 31'd3, 32'h0, 0, 0, 0);
        add_cmd(pbis_pkg::KIND_RETRIEVE, 32'h0, 31'd0, 32'h0, 0, 0, 0);
        add_cmd(pbis_pkg::KIND_RETRIEVE, 32'h0, 31'd2, 32'h0, 0, 0, 0);
        add_cmd(pbis_pkg::KIND_EXPIRY, 32'h0, 31'h0, 32'd81, 0, 0, 0);
        add_cmd(pbis_pkg::KIND_RETRIEVE, 32'h0, 31'd4, 32'h0, 0, 0, 0);
        add_cmd(KIND_UNUSED, 32'h0, 31'h0, 32'h0, 0, 0, 0);
        add_cmd(pbis_pkg::KIND_STORE, 32'h5A5A_5A5A, 31'h7FFF_FFFF, 32'h0, 0, 0, 0);
        wait_idle();

        // Small limit with zero expiry: refused store and the strict age comparison.
        set_registers(16'd2, 16'd0);
        add_cmd(pbis_pkg::KIND_STORE, 32'h1234_5678, 31'h0, 32'h0, 0, 0, 0);
        add_cmd(pbis_pkg::KIND_STORE, 32'h8765_4321, 31'h0, 32'h0, 0, 0, 0);
        add_cmd(pbis_pkg::KIND_EXPIRY, 32'h0, 31'h0, 32'h0, 0, 0, 0);
        add_cmd(pbis_pkg::KIND_EXPIRY, 32'h0, 31'h0, 32'h1, 0, 0, 0);
        wait_idle();

        // Zero limit refuses every store; retrieve still works.
        set_registers(16'd0, 16'd0);
        add_cmd(pbis_pkg::KIND_STORE, 32'hDEAD_BEEF, 31'h0, 32'h0, 0, 0, 0);
        add_cmd(pbis_pkg::KIND_RETRIEVE, 32'h0, 31'd6, 32'h0, 0, 0, 0);
        wait_idle();

        // Limit above the table size and the largest expiry.
        set_registers(16'd127, 16'hFFFF);
        add_cmd(pbis_pkg::KIND_STORE, 32'hC0DE_0001, 31'h0, 32'h0, 0, 0, 0);
        add_cmd(pbis_pkg::KIND_EXPIRY, 32'h0, 31'h0, 32'h0000_FFFF, 0, 0, 0);
        add_cmd(pbis_pkg::KIND_EXPIRY, 32'h0, 31'h0, 32'h0001_0000, 0, 0, 0);
        wait_idle();

        // Random phases: store-heavy phases fill the table, the others drain it.
        for (int ph = 0; ph < PHASE_COUNT; ph++)
        begin
            set_registers(phase_limit[ph], phase_expiry[ph]);
            steady_mode = (ph % 3 == 1);
            sw = (ph % 2 == 0) ? 55 : 30;
            if (ph == 2)
                clock_now = 32'hFFFF_FF00;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(0, 49) == 0)
                    clock_now = clock_now + $urandom;
                else
                    clock_now = clock_now + $urandom_range(0, 4);
                case ($urandom_range(0, 5))
                    0: offset = 32'hFFFF_FFFF;
                    1: offset = 32'h0;
                    2: offset = 32'h1;
                    3: offset = 32'h2;
                    4: offset = $urandom_range(3, 200);
                    default: offset = 32'h0 - $urandom_range(2, 200);
                endcase
                r = $urandom_range(0, 99);
                if (r < 3)
                    add_cmd(KIND_UNUSED, $urandom, pbis_pkg::ID_W'($urandom), $urandom,
                            0, 0, 0);
                else if (r < 3 + sw)
                    add_cmd(pbis_pkg::KIND_STORE, $urandom, pbis_pkg::ID_W'($urandom),
                            clock_now, 0, 0, 0);
                else
                begin
                    rem = r - 3 - sw;
                    if (rem < 20)
                        add_cmd(pbis_pkg::KIND_RETRIEVE, $urandom, pbis_pkg::ID_W'($urandom),
                                $urandom, 1, 0, 0);
                    else if (rem < 26)
                        add_cmd(pbis_pkg::KIND_RETRIEVE, $urandom, pbis_pkg::ID_W'($urandom),
                                $urandom, 0, 0, 0);
                    else if (rem < 38)
                        add_cmd(pbis_pkg::KIND_EXPIRY, $urandom, pbis_pkg::ID_W'($urandom),
                                $urandom, 0, 1, offset);
                    else if (rem < 44)
                        add_cmd(pbis_pkg::KIND_EXPIRY, $urandom, pbis_pkg::ID_W'($urandom),
                                clock_now, 0, 0, 0);
                    else
                        add_cmd(pbis_pkg::KIND_RETRIEVE, $urandom, pbis_pkg::ID_W'($urandom),
                                $urandom, 1, 0, 0);
                end
            end
            wait_idle();
        end

        // Let any stray result show up before the verdict.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_answers.size() != 0)
            note_failure($sformatf("%0d results never arrived", expected_answers.size()));
        if (fail_count == 0)
            $display("packet_buffer_id_store_top_tb passed");
        else
            $display("packet_buffer_id_store_top_tb failed");
        $finish;
    end

endmodule

// File: files.f
hdl/pbis_pkg.sv
hdl/pbis_ram.sv
hdl/packet_buffer_id_store_top.sv
hdl/pbis_chk.sv
tb/packet_buffer_id_store_top_tb.sv
